/* sv/rab_pkg.sv */
// ============================================================================
// rab_pkg
// Shared types and constants for the rotated alpha blit pixel block.
// ============================================================================
package rab_pkg;

    // Framebuffer geometry
    localparam int FB_WIDTH   = 256;
    localparam int FB_HEIGHT  = 256;
    localparam int FB_WORDS   = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W     = $clog2(FB_WORDS);
    localparam int SPRITE_MAX = 128;

    // Field widths
    localparam int OFF_W   = 7;
    localparam int COORD_W = 12;
    localparam int MAT_W   = 16;
    localparam int PIX_W   = 32;
    localparam int IDX_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int DELTA_W = 14;               // dest + off - pivot
    localparam int PROD_W  = DELTA_W + MAT_W;  // one matrix product
    localparam int SUM_W   = PROD_W + 1;       // sum of two products
    localparam int Q_SHIFT = 14;               // Q2.14 fraction bits
    localparam int POS_W   = SUM_W - Q_SHIFT + 1;
    localparam int LIN_W   = 32;               // signed linear index

    // Reset values
    localparam logic signed [MAT_W-1:0] Q_ONE = 16'sd16384;
    localparam logic [PIX_W-1:0] WHITE = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_C   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_D   = 3'd7;

    typedef struct packed {
        logic [OFF_W-1:0] off_x;
        logic [OFF_W-1:0] off_y;
        logic [PIX_W-1:0] src_pixel;   // B G R A
    } pixel_in_t;

    typedef struct packed {
        logic             written;
        logic [IDX_W-1:0] write_index;
        logic [PIX_W-1:0] pixel_out;   // A R G B
    } pixel_res_t;

endpackage

/* sv/rab_ram.sv */
// ============================================================================
// rab_ram
// Generic single write port, single read port RAM with registered read.
// A read at the address being written returns the old word.
// ============================================================================
module rab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rotated_alpha_blit_pixel.sv */
// ============================================================================
// rotated_alpha_blit_pixel
// Rotates a sprite pixel into the framebuffer and alpha blends it there.
// ============================================================================
//
//  channel  | valid      | stall      | payload               | direction
//  ---------+------------+------------+-----------------------+----------
//  input    | in_valid   | in_stall   | in_data   (pixel_in_t)  | in
//  result   | out_valid  | out_stall  | out_data  (pixel_res_t) | out
//  config   | cfg_we     | -          | cfg_index, cfg_wdata  | in
//
//  One pixel per cycle sustained unless out_stall holds the result; each
//  result is presented from the OUT register. The rate is set by the
//  framebuffer RAM, which does one read and one write per cycle; a one-word
//  forwarding register covers back-to-back hits on the same word.
//  After reset the block clears all FB_WORDS (65536) framebuffer words to
//  white, one word a cycle; in_stall stays high meanwhile.
//  A stalled result freezes the whole pipeline, RAM read register included.
//
//  Pipeline:
//    P1  delta from pivot          (dx, dy)
//    P2  four matrix products
//    P3  product sums
//    P4  truncate toward zero, add pivot back  (x, y)
//    A   linear index, range check; RAM read issued
//    B   read data (or forwarded word), blend, write back
//    OUT result register
// ============================================================================
module rotated_alpha_blit_pixel
    import rab_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pixel_in_t            in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pixel_res_t           out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] dest_x_reg, dest_y_reg, pivot_x_reg, pivot_y_reg;
    logic signed [MAT_W-1:0]   mat_a_reg, mat_b_reg, mat_c_reg, mat_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg  <= '0;
            dest_y_reg  <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            mat_a_reg   <= Q_ONE;
            mat_b_reg   <= '0;
            mat_c_reg   <= '0;
            mat_d_reg   <= Q_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEST_X:  dest_x_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_DEST_Y:  dest_y_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_PIVOT_X: pivot_x_reg <= cfg_wdata[COORD_W-1:0];
                CFG_PIVOT_Y: pivot_y_reg <= cfg_wdata[COORD_W-1:0];
                CFG_MAT_A:   mat_a_reg   <= cfg_wdata[MAT_W-1:0];
                CFG_MAT_B:   mat_b_reg   <= cfg_wdata[MAT_W-1:0];
                CFG_MAT_C:   mat_c_reg   <= cfg_wdata[MAT_W-1:0];
                CFG_MAT_D:   mat_d_reg   <= cfg_wdata[MAT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: one advance signal for the whole pipeline. The result
    // register takes a new entry whenever it is empty or being drained.
    // ------------------------------------------------------------------
    logic clearing_reg;
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = clearing_reg || !adv;

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(FB_WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage valids
    // ------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic a_valid_reg, b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= in_valid && !clearing_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            a_valid_reg   <= p4_valid_reg;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // P1: offsets relative to the pivot
    // ------------------------------------------------------------------
    logic signed [DELTA_W-1:0] dx_next, dy_next;
    logic                      skip_next;

    assign dx_next = DELTA_W'(dest_x_reg) + $signed({{(DELTA_W-OFF_W){1'b0}}, in_data.off_x})
                   - DELTA_W'(pivot_x_reg);
    assign dy_next = DELTA_W'(dest_y_reg) + $signed({{(DELTA_W-OFF_W){1'b0}}, in_data.off_y})
                   - DELTA_W'(pivot_y_reg);
    // offsets past the sprite size are dropped like off-screen pixels
    assign skip_next = (11'(in_data.off_x) >= 11'(SPRITE_MAX))
                    || (11'(in_data.off_y) >= 11'(SPRITE_MAX));

    logic signed [DELTA_W-1:0] p1_dx_reg, p1_dy_reg;
    logic                      p1_skip_reg;
    logic [PIX_W-1:0]          p1_src_reg;

    // ------------------------------------------------------------------
    // P2: matrix products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p2_pa_reg, p2_pb_reg, p2_pc_reg, p2_pd_reg;
    logic                     p2_skip_reg;
    logic [PIX_W-1:0]         p2_src_reg;

    // ------------------------------------------------------------------
    // P3: sums
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] p3_sx_reg, p3_sy_reg;
    logic                    p3_skip_reg;
    logic [PIX_W-1:0]        p3_src_reg;

    // ------------------------------------------------------------------
    // P4: shift out the Q2.14 fraction, rounding toward zero, then move
    // back to framebuffer coordinates
    // ------------------------------------------------------------------
    logic rnd_x, rnd_y;
    logic signed [POS_W-1:0] x_next, y_next;

    assign rnd_x = p3_sx_reg[SUM_W-1] && (p3_sx_reg[Q_SHIFT-1:0] != '0);
    assign rnd_y = p3_sy_reg[SUM_W-1] && (p3_sy_reg[Q_SHIFT-1:0] != '0);
    assign x_next = POS_W'(pivot_x_reg) + POS_W'($signed(p3_sx_reg[SUM_W-1:Q_SHIFT]))
                  + $signed({{(POS_W-1){1'b0}}, rnd_x});
    assign y_next = POS_W'(pivot_y_reg) + POS_W'($signed(p3_sy_reg[SUM_W-1:Q_SHIFT]))
                  + $signed({{(POS_W-1){1'b0}}, rnd_y});

    logic signed [POS_W-1:0] p4_x_reg, p4_y_reg;
    logic                    p4_skip_reg;
    logic [PIX_W-1:0]        p4_src_reg;

    // ------------------------------------------------------------------
    // A: linear index and range check; only the linear index is checked,
    // so a column off the row wraps into the neighbor row
    // ------------------------------------------------------------------
    logic signed [LIN_W-1:0] lin_idx;
    logic                    hit_next;

    assign lin_idx  = LIN_W'(p4_x_reg) + LIN_W'(p4_y_reg) * LIN_W'(FB_WIDTH);
    assign hit_next = !p4_skip_reg && !lin_idx[LIN_W-1] && (lin_idx < LIN_W'(FB_WORDS));

    logic              a_hit_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [PIX_W-1:0]  a_src_reg;

    logic              b_hit_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [PIX_W-1:0]  b_src_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_dx_reg   <= dx_next;
            p1_dy_reg   <= dy_next;
            p1_skip_reg <= skip_next;
            p1_src_reg  <= in_data.src_pixel;

            p2_pa_reg   <= PROD_W'(p1_dx_reg) * PROD_W'(mat_a_reg);
            p2_pb_reg   <= PROD_W'(p1_dy_reg) * PROD_W'(mat_b_reg);
            p2_pc_reg   <= PROD_W'(p1_dx_reg) * PROD_W'(mat_c_reg);
            p2_pd_reg   <= PROD_W'(p1_dy_reg) * PROD_W'(mat_d_reg);
            p2_skip_reg <= p1_skip_reg;
            p2_src_reg  <= p1_src_reg;

            p3_sx_reg   <= SUM_W'(p2_pa_reg) - SUM_W'(p2_pb_reg);
            p3_sy_reg   <= SUM_W'(p2_pc_reg) + SUM_W'(p2_pd_reg);
            p3_skip_reg <= p2_skip_reg;
            p3_src_reg  <= p2_src_reg;

            p4_x_reg    <= x_next;
            p4_y_reg    <= y_next;
            p4_skip_reg <= p3_skip_reg;
            p4_src_reg  <= p3_src_reg;

            a_hit_reg   <= hit_next;
            a_addr_reg  <= lin_idx[ADDR_W-1:0];
            a_src_reg   <= p4_src_reg;

            b_hit_reg   <= a_hit_reg;
            b_addr_reg  <= a_addr_reg;
            b_src_reg   <= a_src_reg;
        end
    end

    // ------------------------------------------------------------------
    // Framebuffer
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata;
    logic              blit_we;
    logic [PIX_W-1:0]  blend_word;

    assign blit_we   = adv && b_valid_reg && b_hit_reg;
    assign ram_we    = clearing_reg || blit_we;
    assign ram_waddr = clearing_reg ? clr_cnt_reg : b_addr_reg;
    assign ram_wdata = clearing_reg ? WHITE : blend_word;

    rab_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FB_WORDS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (a_addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Forwarding: the write made on the edge that launched this read is
    // not in the read data, so keep the last blit write at hand.
    // ------------------------------------------------------------------
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [PIX_W-1:0]  fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (blit_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blit_we)
        begin
            fwd_addr_reg <= b_addr_reg;
            fwd_data_reg <= blend_word;
        end
    end

    logic [PIX_W-1:0] dst_word;

    assign dst_word = (fwd_valid_reg && (fwd_addr_reg == b_addr_reg)) ? fwd_data_reg
                                                                      : ram_rdata;

    // ------------------------------------------------------------------
    // B: blend, dst + trunc((src - dst) * a / 255)
    // floor(n / 255) = (n + (n >> 8) + 1) >> 8 holds for n <= 255 * 255
    // ------------------------------------------------------------------
    function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a);
        logic        neg;
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [15:0] acc;
        logic [7:0]  quo;
        neg  = s < d;
        mag  = neg ? (d - s) : (s - d);
        prod = 16'(mag) * 16'(a);
        acc  = prod + {8'b0, prod[15:8]} + 16'd1;
        quo  = acc[15:8];
        return neg ? (d - quo) : (d + quo);
    endfunction

    logic [7:0] src_b, src_g, src_r, src_a;
    logic [7:0] new_r, new_g, new_b;

    assign src_b = b_src_reg[31:24];
    assign src_g = b_src_reg[23:16];
    assign src_r = b_src_reg[15:8];
    assign src_a = b_src_reg[7:0];

    assign new_r = blend_ch(src_r, dst_word[23:16], src_a);
    assign new_g = blend_ch(src_g, dst_word[15:8],  src_a);
    assign new_b = blend_ch(src_b, dst_word[7:0],   src_a);

    assign blend_word = {src_a, new_r, new_g, new_b};

    // ------------------------------------------------------------------
    // Result register; skipped pixels report all zeros
    // ------------------------------------------------------------------
    pixel_res_t out_data_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b_hit_reg)
            begin
                out_data_reg.written     <= 1'b1;
                out_data_reg.write_index <= IDX_W'(b_addr_reg);
                out_data_reg.pixel_out   <= blend_word;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // nothing may reach the blend stage while the clearing pass owns the RAM
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!b_valid_reg && !a_valid_reg))
        else $error("pixel in flight during framebuffer clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !out_valid_reg)
        else $error("result presented during framebuffer clear");

    // a skipped pixel must report zero index and word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.written) |->
            (out_data_reg.write_index == '0 && out_data_reg.pixel_out == '0))
        else $error("skipped pixel reported nonzero payload");

    // a blit write always carries the result that is reported next
    assert property (@(posedge clk) disable iff (!rst_n)
        blit_we |=> (out_valid_reg && out_data_reg.written
                     && out_data_reg.pixel_out == $past(blend_word)))
        else $error("framebuffer write and reported word differ");
`endif

endmodule
